### rtl/cbsm_pkg.sv
`default_nettype none

package cbsm_pkg;

  localparam int ADC_BITS_DEFAULT = 12;

  // queue between front and back; keep it a power of two
  localparam int QUEUE_DEPTH = 2;

  localparam int ENERGY_W = 52;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x
  localparam logic [31:0] DIV100_MAGIC = 32'd1374389535;
  localparam int DIV100_SHIFT = 37;

  localparam logic [1:0] CFG_LOCKOUT   = 2'd0;
  localparam logic [1:0] CFG_FS_VOLT   = 2'd1;
  localparam logic [1:0] CFG_FS_CURR   = 2'd2;

  localparam logic [15:0] LOCKOUT_RESET = 16'd200;
  localparam logic [15:0] FS_VOLT_RESET = 16'd25000;
  localparam logic [15:0] FS_CURR_RESET = 16'd32000;

  // per-sample result of the button logic, handed to the back end
  typedef struct packed {
    logic        charging;
    logic        ev_in;
    logic        ev_out;
    logic [31:0] session_start;
    logic [15:0] elapsed;
  } ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_V,
    B_FOLD_V,
    B_MUL_I,
    B_FOLD_I,
    B_MUL_P,
    B_DIV_P,
    B_PWR,
    B_MUL_E,
    B_ACC
  } bstate_t;

endpackage

`default_nettype wire

### rtl/cbsm_front.sv
`default_nettype none

module cbsm_front #(
  parameter int ADC_BITS = cbsm_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ADC_BITS-1:0] raw_voltage,
  input  wire logic [ADC_BITS-1:0] raw_current,
  input  wire logic                plug_in_pressed,
  input  wire logic                plug_out_pressed,
  input  wire logic [31:0]         now_ms,
  input  wire logic [15:0]         elapsed_ms,
  input  wire logic [15:0]         lockout_ms,
  output logic                     push,
  input  wire logic                push_ready,
  output cbsm_pkg::ctl_t           push_ctl,
  output logic [ADC_BITS-1:0]      push_raw_v,
  output logic [ADC_BITS-1:0]      push_raw_i
);

  logic        charging_flag;
  logic [31:0] last_in;
  logic [31:0] last_out;
  logic [31:0] session_start;

  logic        charging_flag_next;
  logic [31:0] last_in_next;
  logic [31:0] last_out_next;
  logic [31:0] session_start_next;
  logic        ev_in;
  logic        ev_out;
  logic        pin_ok;
  logic        pout_ok;
  logic [31:0] d_in;
  logic [31:0] d_out;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  assign d_in    = now_ms - last_in;
  assign d_out   = now_ms - last_out;
  assign pin_ok  = plug_in_pressed  && (d_in  > {16'd0, lockout_ms});
  assign pout_ok = plug_out_pressed && (d_out > {16'd0, lockout_ms});

  // plug-in first, then plug-out sees the updated status
  always_comb begin
    charging_flag_next = charging_flag;
    session_start_next = session_start;
    last_in_next       = last_in;
    last_out_next      = last_out;
    ev_in              = 1'b0;
    ev_out             = 1'b0;
    if (pin_ok) begin
      last_in_next = now_ms;
      if (!charging_flag) begin
        charging_flag_next = 1'b1;
        session_start_next = now_ms;
        ev_in              = 1'b1;
      end
    end
    if (pout_ok) begin
      last_out_next = now_ms;
      if (charging_flag_next) begin
        charging_flag_next = 1'b0;
        session_start_next = 32'd0;
        ev_out             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging_flag <= 1'b0;
      last_in       <= 32'd0;
      last_out      <= 32'd0;
      session_start <= 32'd0;
    end else if (push) begin
      charging_flag <= charging_flag_next;
      last_in       <= last_in_next;
      last_out      <= last_out_next;
      session_start <= session_start_next;
    end
  end

  assign push_ctl.charging      = charging_flag_next;
  assign push_ctl.ev_in         = ev_in;
  assign push_ctl.ev_out        = ev_out;
  assign push_ctl.session_start = session_start_next;
  assign push_ctl.elapsed       = elapsed_ms;
  assign push_raw_v             = raw_voltage;
  assign push_raw_i             = raw_current;

endmodule

`default_nettype wire

### rtl/cbsm_queue.sv
`default_nettype none

module cbsm_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int DEPTH = cbsm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cbsm_back.sv
`default_nettype none

module cbsm_back #(
  parameter int ADC_BITS = cbsm_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  input  wire cbsm_pkg::ctl_t              q_ctl,
  input  wire logic [ADC_BITS-1:0]         q_raw_v,
  input  wire logic [ADC_BITS-1:0]         q_raw_i,
  input  wire logic [15:0]                 full_scale_voltage_cv,
  input  wire logic [15:0]                 full_scale_current_ma,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             charging,
  output logic [15:0]                      voltage_cv,
  output logic [15:0]                      current_ma,
  output logic [25:0]                      power_mw,
  output logic [cbsm_pkg::ENERGY_W-1:0]    energy_mwms,
  output logic [31:0]                      session_start_ms,
  output logic                             plugged_in_event,
  output logic                             unplugged_event
);

  localparam int N  = ADC_BITS;
  localparam int SW = ADC_BITS + 16;
  localparam logic [N-1:0] ADC_MAX = '1;
  localparam int EW = cbsm_pkg::ENERGY_W;
  localparam int SH = cbsm_pkg::DIV100_SHIFT;

  cbsm_pkg::bstate_t state;
  cbsm_pkg::bstate_t state_next;

  cbsm_pkg::ctl_t    e_ctl;
  logic [N-1:0]      e_raw_v;
  logic [N-1:0]      e_raw_i;

  logic [SW-1:0]     s;
  logic [15:0]       q;
  logic [15:0]       v_cv;
  logic [15:0]       i_ma;
  logic [25:0]       p_mw;
  logic [63:0]       prod;
  logic [EW-1:0]     acc;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic              fold_done;
  logic [15:0]       quot;
  logic              out_free;
  logic              load_out;
  logic [EW-1:0]     acc_base;
  logic [EW:0]       acc_sum;
  logic [EW-1:0]     acc_new;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // divide by 2^N-1: fold high part onto low part until it fits in N bits
  assign fold_done = (s[SW-1:N] == '0);
  assign quot      = q + {15'd0, (s[N-1:0] == ADC_MAX)};

  assign out_free = !out_valid || out_ready;
  assign load_out = (state == cbsm_pkg::B_ACC) && out_free;

  assign acc_base = e_ctl.ev_in ? '0 : acc;
  assign acc_sum  = {1'b0, acc_base} + (EW+1)'(prod[41:0]);
  assign acc_new  = !e_ctl.charging ? acc_base :
                    (acc_sum >= {1'b0, cbsm_pkg::ENERGY_MAX}) ? cbsm_pkg::ENERGY_MAX :
                    acc_sum[EW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbsm_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    unique case (state)
      cbsm_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = cbsm_pkg::B_MUL_V;
        end
      end
      cbsm_pkg::B_MUL_V: begin
        mul_a      = 32'(e_raw_v);
        mul_b      = 32'(full_scale_voltage_cv);
        state_next = cbsm_pkg::B_FOLD_V;
      end
      cbsm_pkg::B_FOLD_V: begin
        if (fold_done) begin
          state_next = cbsm_pkg::B_MUL_I;
        end
      end
      cbsm_pkg::B_MUL_I: begin
        // current reads as zero while free
        mul_a      = e_ctl.charging ? 32'(e_raw_i) : 32'd0;
        mul_b      = 32'(full_scale_current_ma);
        state_next = cbsm_pkg::B_FOLD_I;
      end
      cbsm_pkg::B_FOLD_I: begin
        if (fold_done) begin
          state_next = cbsm_pkg::B_MUL_P;
        end
      end
      cbsm_pkg::B_MUL_P: begin
        mul_a      = {16'd0, v_cv};
        mul_b      = {16'd0, i_ma};
        state_next = cbsm_pkg::B_DIV_P;
      end
      cbsm_pkg::B_DIV_P: begin
        mul_a      = prod[31:0];
        mul_b      = cbsm_pkg::DIV100_MAGIC;
        state_next = cbsm_pkg::B_PWR;
      end
      cbsm_pkg::B_PWR: begin
        state_next = cbsm_pkg::B_MUL_E;
      end
      cbsm_pkg::B_MUL_E: begin
        mul_a      = {6'd0, p_mw};
        mul_b      = {16'd0, e_ctl.elapsed};
        state_next = cbsm_pkg::B_ACC;
      end
      cbsm_pkg::B_ACC: begin
        if (out_free) begin
          state_next = cbsm_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = cbsm_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cbsm_pkg::B_IDLE: begin
        if (q_valid) begin
          e_ctl   <= q_ctl;
          e_raw_v <= q_raw_v;
          e_raw_i <= q_raw_i;
        end
      end
      cbsm_pkg::B_MUL_V, cbsm_pkg::B_MUL_I: begin
        s <= mul_p[SW-1:0];
        q <= 16'd0;
      end
      cbsm_pkg::B_FOLD_V, cbsm_pkg::B_FOLD_I: begin
        if (!fold_done) begin
          q <= q + s[SW-1:N];
          s <= SW'(s[SW-1:N]) + SW'(s[N-1:0]);
        end else if (state == cbsm_pkg::B_FOLD_V) begin
          v_cv <= quot;
        end else begin
          i_ma <= quot;
        end
      end
      cbsm_pkg::B_MUL_P, cbsm_pkg::B_DIV_P, cbsm_pkg::B_MUL_E: begin
        prod <= mul_p;
      end
      cbsm_pkg::B_PWR: begin
        p_mw <= prod[SH+25:SH];
      end
      cbsm_pkg::B_ACC: begin
        if (out_free) begin
          charging         <= e_ctl.charging;
          voltage_cv       <= v_cv;
          current_ma       <= i_ma;
          power_mw         <= p_mw;
          session_start_ms <= e_ctl.session_start;
          plugged_in_event <= e_ctl.ev_in;
          unplugged_event  <= e_ctl.ev_out;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        acc       <= acc_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // accumulator only moves on a result load, so it doubles as the output
  assign energy_mwms = acc;

endmodule

`default_nettype wire

### rtl/charging_bay_session_meter.sv
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    raw readings, buttons, now_ms, elapsed_ms
// out       output     out_valid / out_ready  status, scaled values, power, energy, events
// cfg       input      cfg_valid / cfg_ready  cfg_index (0..2), cfg_data (16 bit)
//
// Each sample runs through the back-end sequencer, which finishes it before taking the next:
// one shared 32x32 multiplier used five times plus fold steps for each scaled reading.
// The front classifies buttons in the accept cycle; a 2-entry queue decouples it.
// Synchronous reset restores the register defaults and clears the session state.
// in_ready drops only when the queue is full; a held result stalls the back end.
// cfg_ready is always high.

module charging_bay_session_meter #(
  parameter int ADC_BITS = cbsm_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ADC_BITS-1:0]         raw_voltage,
  input  wire logic [ADC_BITS-1:0]         raw_current,
  input  wire logic                        plug_in_pressed,
  input  wire logic                        plug_out_pressed,
  input  wire logic [31:0]                 now_ms,
  input  wire logic [15:0]                 elapsed_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             charging,
  output logic [15:0]                      voltage_cv,
  output logic [15:0]                      current_ma,
  output logic [25:0]                      power_mw,
  output logic [cbsm_pkg::ENERGY_W-1:0]    energy_mwms,
  output logic [31:0]                      session_start_ms,
  output logic                             plugged_in_event,
  output logic                             unplugged_event,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data
);

  localparam int QW = $bits(cbsm_pkg::ctl_t) + 2 * ADC_BITS;

  logic [15:0] lockout_ms;
  logic [15:0] full_scale_voltage_cv;
  logic [15:0] full_scale_current_ma;

  logic                 push;
  logic                 push_ready;
  cbsm_pkg::ctl_t       push_ctl;
  logic [ADC_BITS-1:0]  push_raw_v;
  logic [ADC_BITS-1:0]  push_raw_i;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  logic                 q_valid;
  logic                 q_pop;
  cbsm_pkg::ctl_t       q_ctl;
  logic [ADC_BITS-1:0]  q_raw_v;
  logic [ADC_BITS-1:0]  q_raw_i;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms            <= cbsm_pkg::LOCKOUT_RESET;
      full_scale_voltage_cv <= cbsm_pkg::FS_VOLT_RESET;
      full_scale_current_ma <= cbsm_pkg::FS_CURR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbsm_pkg::CFG_LOCKOUT: lockout_ms            <= cfg_data;
        cbsm_pkg::CFG_FS_VOLT: full_scale_voltage_cv <= cfg_data;
        cbsm_pkg::CFG_FS_CURR: full_scale_current_ma <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cbsm_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_voltage      (raw_voltage),
    .raw_current      (raw_current),
    .plug_in_pressed  (plug_in_pressed),
    .plug_out_pressed (plug_out_pressed),
    .now_ms           (now_ms),
    .elapsed_ms       (elapsed_ms),
    .lockout_ms       (lockout_ms),
    .push             (push),
    .push_ready       (push_ready),
    .push_ctl         (push_ctl),
    .push_raw_v       (push_raw_v),
    .push_raw_i       (push_raw_i)
  );

  assign q_wdata = {push_ctl, push_raw_v, push_raw_i};
  assign {q_ctl, q_raw_v, q_raw_i} = q_rdata;

  cbsm_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  cbsm_back #(
    .ADC_BITS(ADC_BITS)
  ) u_back (
    .clk                   (clk),
    .rst                   (rst),
    .q_valid               (q_valid),
    .q_pop                 (q_pop),
    .q_ctl                 (q_ctl),
    .q_raw_v               (q_raw_v),
    .q_raw_i               (q_raw_i),
    .full_scale_voltage_cv (full_scale_voltage_cv),
    .full_scale_current_ma (full_scale_current_ma),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .charging              (charging),
    .voltage_cv            (voltage_cv),
    .current_ma            (current_ma),
    .power_mw              (power_mw),
    .energy_mwms           (energy_mwms),
    .session_start_ms      (session_start_ms),
    .plugged_in_event      (plugged_in_event),
    .unplugged_event       (unplugged_event)
  );

  a_free_no_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && !charging |-> current_ma == 16'd0 && power_mw == 26'd0)
    else $error("current reported while bay is free");

  a_free_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !charging |-> session_start_ms == 32'd0)
    else $error("session start held while bay is free");

  a_plugin_charges: assert property (@(posedge clk) disable iff (rst)
    out_valid && plugged_in_event && !unplugged_event |-> charging)
    else $error("plug-in event without charging status");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### test/tb_top.sv
module tb_top;
  import cbsm_pkg::*;

  localparam int ADC_BITS = ADC_BITS_DEFAULT;
  localparam int ADC_FULL = (1 << ADC_BITS) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [ADC_BITS-1:0] raw_voltage;
    logic [ADC_BITS-1:0] raw_current;
    logic                plug_in;
    logic                plug_out;
    logic [31:0]         now_ms;
    logic [15:0]         elapsed_ms;
  } bay_sample_t;

  typedef struct packed {
    logic                charging;
    logic [15:0]         voltage_cv;
    logic [15:0]         current_ma;
    logic [25:0]         power_mw;
    logic [ENERGY_W-1:0] energy_mwms;
    logic [31:0]         session_start_ms;
    logic                plugged_in_event;
    logic                unplugged_event;
  } meter_reading_t;

  typedef enum logic [1:0] {RDY_OPEN, RDY_RANDOM, RDY_STALLS, RDY_TOGGLE} rdy_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADC_BITS-1:0] raw_voltage = '0;
  logic [ADC_BITS-1:0] raw_current = '0;
  logic                plug_in_pressed = 1'b0;
  logic                plug_out_pressed = 1'b0;
  logic [31:0]         now_ms = '0;
  logic [15:0]         elapsed_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                charging;
  logic [15:0]         voltage_cv;
  logic [15:0]         current_ma;
  logic [25:0]         power_mw;
  logic [ENERGY_W-1:0] energy_mwms;
  logic [31:0]         session_start_ms;
  logic                plugged_in_event;
  logic                unplugged_event;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  charging_bay_session_meter #(.ADC_BITS(ADC_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .raw_voltage(raw_voltage), .raw_current(raw_current),
    .plug_in_pressed(plug_in_pressed), .plug_out_pressed(plug_out_pressed),
    .now_ms(now_ms), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .charging(charging), .voltage_cv(voltage_cv), .current_ma(current_ma),
    .power_mw(power_mw), .energy_mwms(energy_mwms), .session_start_ms(session_start_ms),
    .plugged_in_event(plugged_in_event), .unplugged_event(unplugged_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bay model: configuration and session state
  logic [15:0]         bay_lockout = LOCKOUT_RESET;
  logic [15:0]         bay_fs_volt = FS_VOLT_RESET;
  logic [15:0]         bay_fs_curr = FS_CURR_RESET;
  logic                bay_charging = 1'b0;
  logic [31:0]         bay_last_in = '0;
  logic [31:0]         bay_last_out = '0;
  logic [31:0]         bay_start = '0;
  logic [ENERGY_W-1:0] bay_energy = '0;

  bay_sample_t    sample_q[$];
  meter_reading_t reading_q[$];
  bay_sample_t    cur_smp;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_writes = 0;
  int n_sessions = 0;
  int n_ceiling = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  int stall_left = 0;
  rdy_mode_t rdy_mode = RDY_OPEN;
  logic rdy_next;
  logic [31:0] clock_ms = '0;

  function automatic meter_reading_t bay_meter_step(bay_sample_t s);
    meter_reading_t r;
    logic [31:0] since;
    logic [63:0] rv, ri, fv, fi, v, c, p, add, acc, emax;
    r = '0;
    since = s.now_ms - bay_last_in;
    if (s.plug_in && since > {16'd0, bay_lockout}) begin
      bay_last_in = s.now_ms;
      if (!bay_charging) begin
        bay_charging = 1'b1;
        bay_start = s.now_ms;
        bay_energy = '0;
        r.plugged_in_event = 1'b1;
        n_sessions++;
      end
    end
    since = s.now_ms - bay_last_out;
    if (s.plug_out && since > {16'd0, bay_lockout}) begin
      bay_last_out = s.now_ms;
      if (bay_charging) begin
        bay_charging = 1'b0;
        bay_start = '0;
        r.unplugged_event = 1'b1;
      end
    end
    rv = s.raw_voltage;
    ri = s.raw_current;
    fv = bay_fs_volt;
    fi = bay_fs_curr;
    v = (rv * fv) / ADC_FULL;
    c = bay_charging ? (ri * fi) / ADC_FULL : 64'd0;
    p = (v * c) / 100;
    if (bay_charging && s.elapsed_ms != 0) begin
      add = p * s.elapsed_ms;
      acc = bay_energy;
      emax = ENERGY_MAX;
      if (add >= emax - acc) begin
        bay_energy = ENERGY_MAX;
        n_ceiling++;
      end else begin
        bay_energy = acc + add;
      end
    end
    r.charging = bay_charging;
    r.voltage_cv = v[15:0];
    r.current_ma = c[15:0];
    r.power_mw = p[25:0];
    r.energy_mwms = bay_energy;
    r.session_start_ms = bay_start;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_errors < 50) $display("MISMATCH at result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reading_q.push_back(bay_meter_step(cur_smp));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || sample_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_smp = sample_q.pop_front();
          raw_voltage <= cur_smp.raw_voltage;
          raw_current <= cur_smp.raw_current;
          plug_in_pressed <= cur_smp.plug_in;
          plug_out_pressed <= cur_smp.plug_out;
          now_ms <= cur_smp.now_ms;
          elapsed_ms <= cur_smp.elapsed_ms;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
  end

  // receiver: checks each transaction, stalls on a changing pattern
  always @(posedge clk) begin
    meter_reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = reading_q.pop_front();
          compare_field("charging", charging, want.charging);
          compare_field("voltage_cv", voltage_cv, want.voltage_cv);
          compare_field("current_ma", current_ma, want.current_ma);
          compare_field("power_mw", power_mw, want.power_mw);
          compare_field("energy_mwms", energy_mwms, want.energy_mwms);
          compare_field("session_start_ms", session_start_ms, want.session_start_ms);
          compare_field("plugged_in_event", plugged_in_event, want.plugged_in_event);
          compare_field("unplugged_event", unplugged_event, want.unplugged_event);
        end
        n_results++;
      end
      if (mode_left == 0) begin
        rdy_mode = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_OPEN: rdy_next = 1'b1;
        RDY_RANDOM: rdy_next = ($urandom_range(0, 3) != 0);
        RDY_STALLS: begin
          if (stall_left > 0) begin
            stall_left--;
            rdy_next = 1'b0;
          end else begin
            rdy_next = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
          end
        end
        default: rdy_next = ~out_ready;
      endcase
      out_ready <= rdy_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               n_pushed - n_results);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_sample(input logic [ADC_BITS-1:0] rv, input logic [ADC_BITS-1:0] ri,
                             input logic pin, input logic pout,
                             input logic [31:0] now, input logic [15:0] el);
    bay_sample_t s;
    s.raw_voltage = rv;
    s.raw_current = ri;
    s.plug_in = pin;
    s.plug_out = pout;
    s.now_ms = now;
    s.elapsed_ms = el;
    sample_q.push_back(s);
    n_pushed++;
  endtask

  task automatic wait_for_drain();
    while (n_accepted != n_pushed || reading_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOCKOUT: bay_lockout = val;
      CFG_FS_VOLT: bay_fs_volt = val;
      CFG_FS_CURR: bay_fs_curr = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic push_random_samples(input int count);
    logic [31:0] step;
    logic [ADC_BITS-1:0] rv, ri;
    logic [15:0] el;
    int r;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: step = 0;
        1: step = bay_lockout;
        2: step = bay_lockout + 32'd1;
        3, 4: step = $urandom_range(0, bay_lockout);
        5: step = $urandom;
        default: step = bay_lockout + $urandom_range(1, 300);
      endcase
      clock_ms += step;
      case ($urandom_range(0, 5))
        0: rv = '0;
        1: rv = ADC_FULL;
        default: rv = $urandom_range(0, ADC_FULL);
      endcase
      case ($urandom_range(0, 5))
        0: ri = '0;
        1: ri = ADC_FULL;
        default: ri = $urandom_range(0, ADC_FULL);
      endcase
      case ($urandom_range(0, 5))
        0: el = '0;
        1: el = 16'hFFFF;
        2: el = $urandom;
        default: el = $urandom_range(1, 2000);
      endcase
      r = $urandom_range(0, 15);
      push_sample(rv, ri, (r < 3) || (r == 15), (r >= 3 && r < 6) || (r == 15), clock_ms, el);
    end
  endtask

  task automatic run_phase(input logic [15:0] lock, input logic [15:0] fsv,
                           input logic [15:0] fsi, input int count);
    wait_for_drain();
    repeat (20) @(posedge clk);
    write_reg(CFG_LOCKOUT, lock);
    write_reg(CFG_FS_VOLT, fsv);
    write_reg(CFG_FS_CURR, fsi);
    push_random_samples(count / 2);
    // sender holds off mid-phase until the block has drained
    wait_for_drain();
    push_random_samples(count - count / 2);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed samples at reset configuration
    push_sample(0, 0, 0, 0, 32'd0, 16'd0);
    push_sample(ADC_FULL, ADC_FULL, 0, 0, 32'd50, 16'hFFFF);
    push_sample(ADC_FULL, ADC_FULL, 1, 0, 32'd100, 16'd10);
    push_sample(ADC_FULL, ADC_FULL, 1, 0, 32'd200, 16'd10);   // diff equals lockout
    push_sample(ADC_FULL, ADC_FULL, 1, 0, 32'd201, 16'd0);    // start, no elapsed time
    push_sample(ADC_FULL, ADC_FULL, 0, 0, 32'd300, 16'hFFFF);
    push_sample(0, ADC_FULL, 0, 0, 32'd310, 16'hFFFF);
    push_sample(ADC_FULL, 0, 0, 0, 32'd320, 16'hFFFF);
    push_sample(2048, 1000, 1, 0, 32'd600, 16'd100);          // plug-in while charging
    push_sample(2048, 1000, 1, 0, 32'd700, 16'd100);
    push_sample(1234, 3000, 0, 1, 32'd800, 16'd50);
    push_sample(1234, 3000, 0, 0, 32'd900, 16'd500);          // free, energy held
    push_sample(1234, 3000, 0, 1, 32'd1200, 16'd50);          // plug-out while free
    push_sample(ADC_FULL, ADC_FULL, 1, 1, 32'd1500, 16'd77);  // start and end together
    push_sample(ADC_FULL, ADC_FULL, 1, 1, 32'd1600, 16'd77);
    push_sample(100, 200, 1, 0, 32'hFFFF_FF00, 16'd1000);
    push_sample(100, 200, 0, 0, 32'hFFFF_FFFF, 16'd1000);
    push_sample(100, 200, 1, 0, 32'h0000_0010, 16'd1000);     // lockout across the wrap
    push_sample(100, 200, 0, 1, 32'h0000_0020, 16'd1000);
    push_sample(ADC_FULL, ADC_FULL, 0, 0, 32'h0000_0030, 16'd0);
    clock_ms = 32'h100;

    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 160);
    run_phase(16'hFFFF, 16'd0, 16'd0, 160);
    run_phase(16'd1, 16'hFFFF, 16'd1, 160);
    run_phase(LOCKOUT_RESET, FS_VOLT_RESET, FS_CURR_RESET, 160);
    run_phase($urandom, $urandom, $urandom, 160);
    run_phase($urandom_range(0, 1000), $urandom, 16'hFFFF, 160);

    // one long full-power session to build up a large energy total
    wait_for_drain();
    repeat (20) @(posedge clk);
    write_reg(CFG_LOCKOUT, 16'd0);
    write_reg(CFG_FS_VOLT, 16'hFFFF);
    write_reg(CFG_FS_CURR, 16'hFFFF);
    clock_ms = bay_last_in + 32'd5000;
    push_sample(ADC_FULL, ADC_FULL, 0, 1, clock_ms, 16'd0);
    clock_ms += 7;
    push_sample(ADC_FULL, ADC_FULL, 1, 0, clock_ms, 16'hFFFF);
    for (int k = 0; k < 200; k++) begin
      clock_ms += $urandom_range(1, 50);
      push_sample(($urandom_range(0, 7) != 0) ? ADC_FULL : $urandom_range(0, ADC_FULL),
                  ($urandom_range(0, 7) != 0) ? ADC_FULL : $urandom_range(0, ADC_FULL),
                  $urandom_range(0, 1), 1'b0, clock_ms,
                  ($urandom_range(0, 7) != 0) ? 16'hFFFF : 16'($urandom));
    end
    clock_ms += 3;
    push_sample(ADC_FULL, ADC_FULL, 0, 1, clock_ms, 16'hFFFF);
    clock_ms += 3;
    push_sample(ADC_FULL, ADC_FULL, 0, 0, clock_ms, 16'hFFFF);
    clock_ms += 3;
    push_sample(ADC_FULL, ADC_FULL, 1, 0, clock_ms, 16'hFFFF);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d samples across %0d register writes",
             n_results, n_accepted, n_writes);
    $display("%0d sessions started, energy ceiling hit on %0d samples", n_sessions, n_ceiling);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
